// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers. Each macro expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property holds at every clock edge outside reset
`define ASSERT_CLKED(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// expression is never true at a clock edge outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLKED(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, codes and helpers of the priority square dilation block.
// ----------------------------------------------------------------------------
package psd_pkg;

	// centre classes on the input
	localparam logic [1:0] CLS_NONE    = 2'd0;
	localparam logic [1:0] CLS_VILLAGE = 2'd1;
	localparam logic [1:0] CLS_SHOP    = 2'd2;

	// output colors
	localparam logic [1:0] COLOR_WHITE = 2'd0;
	localparam logic [1:0] COLOR_RED   = 2'd1;
	localparam logic [1:0] COLOR_GREEN = 2'd2;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// field widths
	localparam int IW_W    = 11;
	localparam int IH_W    = 12;
	localparam int CFG_W   = 12;
	localparam int ROW_W   = 13;   // holds row H+1 for H up to 4095
	localparam int LINE_W  = 8;    // four rows of 2-bit classes
	localparam int WIN_W   = 10;   // five 2-bit column summaries
	localparam int MIN_DIM = 5;

	localparam logic [IW_W-1:0] IW_RESET = 11'd64;
	localparam logic [IH_W-1:0] IH_RESET = 12'd64;

	// one word in the read stage
	typedef struct packed {
		logic [1:0]        cls;         // masked class of this position
		logic              store_hit;   // column inside the picture width
		logic [LINE_W-1:0] mask;        // hides rows not yet received
		logic              first_col;   // restart the column window
		logic              emit;        // position produces a pixel
		logic              last;        // final pixel of the picture
	} psd_stage_t;

	// class code to summary bits: bit 0 village, bit 1 shop
	function automatic logic [1:0] class_bits(input logic [1:0] cls);
		logic [1:0] bits;
		case (cls)
			CLS_SHOP:    bits = 2'b10;
			CLS_VILLAGE: bits = 2'b01;
			default:     bits = 2'b00;
		endcase
		return bits;
	endfunction

endpackage

// ===== rtl/core/psd_line_ram.sv =====
// ----------------------------------------------------------------------------
// psd_line_ram
// Single-port-write, registered-read line store: four rows of classes per column.
// ----------------------------------------------------------------------------
module psd_line_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [psd_pkg::LINE_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [psd_pkg::LINE_W-1:0] wr_data
);
	import psd_pkg::*;

	logic [LINE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/priority_square_dilation.sv =====
// ----------------------------------------------------------------------------
// priority_square_dilation
// A pixel word passes the read stage and the output register after the stream position that completes it.
// Throughput: one stream word per cycle while not stalled; a pixel stall holds the input in the same cycle.
// Reset: asynchronous, active low; clears counters, window and valids, sizes to 64.
// The line store is not cleared. Picture: (W+2) x (H+2) words in, W x H pixels out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_square_dilation #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration writes
	input  logic                     wr_en,
	input  logic                     wr_index,
	input  logic [psd_pkg::CFG_W-1:0] wr_data,
	// centre stream
	input  logic                     src_valid,
	output logic                     src_stall,
	input  logic [1:0]               centre_class,
	// pixel stream
	output logic                     pix_valid,
	input  logic                     pix_stall,
	output logic [1:0]               pixel_color,
	output logic                     frame_last
);
	import psd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 2);
	localparam int AW = $clog2(MAX_WIDTH);

	// configuration registers
	logic [IW_W-1:0] image_width_q;
	logic [IH_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IW_RESET;
			image_height_q <= IH_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:  image_width_q  <= wr_data[IW_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= wr_data[IH_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped picture size
	logic [CW-1:0]    w_eff;
	logic [ROW_W-1:0] h_eff;

	always_comb begin
		if (int'(image_width_q) < MIN_DIM) begin
			w_eff = CW'(MIN_DIM);
		end else if (int'(image_width_q) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(image_width_q);
		end
		if (int'(image_height_q) < MIN_DIM) begin
			h_eff = ROW_W'(MIN_DIM);
		end else begin
			h_eff = ROW_W'(image_height_q);
		end
	end

	// handshake
	logic       valid_s1;
	psd_stage_t word_s1;
	logic       s1_adv;
	logic       src_acc;
	logic       pix_valid_q;

	assign s1_adv    = valid_s1 && (!pix_valid_q || !pix_stall);
	assign src_stall = valid_s1 && !s1_adv;
	assign src_acc   = src_valid && !src_stall;

	// stream position
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW:0]      col_x;
	logic [CW:0]      w_x;
	logic [CW:0]      col_inc;
	logic [ROW_W-1:0] row_inc;
	logic             border;
	psd_stage_t       s0;

	assign col_x   = {1'b0, col_q};
	assign w_x     = {1'b0, w_eff};
	assign col_inc = col_x + (CW+1)'(1);
	assign row_inc = row_q + ROW_W'(1);

	// classify the incoming word
	always_comb begin
		border = (col_q < CW'(2)) || (col_x + (CW+1)'(2) >= w_x) ||
			(row_q < ROW_W'(2)) || (row_q + ROW_W'(2) >= h_eff);
		if (border) begin
			s0.cls = CLS_NONE;
		end else begin
			case (centre_class)
				CLS_SHOP:    s0.cls = CLS_SHOP;
				CLS_VILLAGE: s0.cls = CLS_VILLAGE;
				default:     s0.cls = CLS_NONE;
			endcase
		end
		s0.store_hit = col_x < w_x;
		case (row_q)
			ROW_W'(0): s0.mask = 8'h00;
			ROW_W'(1): s0.mask = 8'h03;
			ROW_W'(2): s0.mask = 8'h0F;
			ROW_W'(3): s0.mask = 8'h3F;
			default:   s0.mask = 8'hFF;
		endcase
		s0.first_col = col_q == '0;
		s0.emit      = (col_q >= CW'(2)) && (row_q >= ROW_W'(2)) &&
			(col_x <= w_x + (CW+1)'(1)) && (row_q <= h_eff + ROW_W'(1));
		s0.last      = (col_x == w_x + (CW+1)'(1)) && (row_q == h_eff + ROW_W'(1));
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (src_acc) begin
			if (col_inc >= w_x + (CW+1)'(2)) begin
				col_q <= '0;
				if (row_inc >= h_eff + ROW_W'(2)) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc;
				end
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// read stage
	logic [AW-1:0] wr_addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc) begin
			word_s1    <= s0;
			wr_addr_s1 <= col_q[AW-1:0];
		end
	end

	// line store: read at acceptance, written back as the word leaves
	logic              ram_re;
	logic              ram_we;
	logic [AW-1:0]     ram_raddr;
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line_new;

	assign ram_re    = src_acc && s0.store_hit;
	assign ram_raddr = s0.store_hit ? col_q[AW-1:0] : '0;
	assign ram_we    = s1_adv && word_s1.store_hit;

	psd_line_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata),
		.wr_en   (ram_we),
		.wr_addr (wr_addr_s1),
		.wr_data (line_new)
	);

	// column summary and 5-wide window
	logic [LINE_W-1:0] line_old;
	logic [1:0]        col_sum;
	logic [WIN_W-1:0]  win_q;
	logic [WIN_W-1:0]  win_next;
	logic [1:0]        agg;
	logic [1:0]        color;

	always_comb begin
		line_old = ram_rdata & word_s1.mask;
		line_new = {line_old[5:0], word_s1.cls};
		if (word_s1.store_hit) begin
			col_sum = class_bits(word_s1.cls) | class_bits(line_old[1:0]) |
				class_bits(line_old[3:2]) | class_bits(line_old[5:4]) |
				class_bits(line_old[7:6]);
		end else begin
			col_sum = 2'b00;
		end
		win_next = (word_s1.first_col ? '0 : {win_q[WIN_W-3:0], 2'b00}) |
			{{(WIN_W-2){1'b0}}, col_sum};
		agg = win_next[1:0] | win_next[3:2] | win_next[5:4] |
			win_next[7:6] | win_next[9:8];
		if (agg[1]) begin
			color = COLOR_GREEN;
		end else if (agg[0]) begin
			color = COLOR_RED;
		end else begin
			color = COLOR_WHITE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= win_next;
		end
	end

	// output register
	logic [1:0] color_q;
	logic       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (s1_adv) begin
			pix_valid_q <= word_s1.emit;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && word_s1.emit) begin
			color_q <= color;
			last_q  <= word_s1.last;
		end
	end

	assign pix_valid   = pix_valid_q;
	assign pixel_color = color_q;
	assign frame_last  = last_q;

	// checks
	`ASSERT_NEVER(a_ram_conflict, ram_re && ram_we && (ram_raddr == wr_addr_s1), "line store read and write hit the same column")
	`ASSERT_CLKED(a_stall_only_full, src_stall |-> valid_s1, "input stalled with read stage empty")
	`ASSERT_CLKED(a_emit_reaches_out, (s1_adv && word_s1.emit) |=> pix_valid_q, "emitting word lost before output register")

endmodule

// ===== tb/sv/priority_square_dilation_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_square_dilation_checker
// Watches the centre and pixel channels and the register port of the square
// dilation block. It keeps its own raster position, line history and column
// window, predicts each pixel word and compares it with the block's output.
// ----------------------------------------------------------------------------
module priority_square_dilation_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic                      wr_index,
	input  logic [psd_pkg::CFG_W-1:0] wr_data,
	input  logic                      src_valid,
	input  logic                      src_stall,
	input  logic [1:0]                centre_class,
	input  logic                      pix_valid,
	input  logic                      pix_stall,
	input  logic [1:0]                pixel_color,
	input  logic                      frame_last,
	output int                        fail_count,
	output int                        pending,
	output logic                      at_origin
);
	import psd_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [1:0] color;
		logic       last;
	} pixel_word_t;

	pixel_word_t expected_pixels[$];

	// predicted block state
	logic [IW_W-1:0]   width_reg;
	logic [IH_W-1:0]   height_reg;
	logic [LINE_W-1:0] row_history [MAX_WIDTH];
	logic [WIN_W-1:0]  summary_window;
	logic [IW_W-1:0]   col_pos;
	logic [ROW_W-1:0]  row_pos;

	// bit 0: village seen, bit 1: shop seen
	function automatic logic [1:0] summary_of(input logic [1:0] cls);
		if (cls == CLS_SHOP)
			return 2'b10;
		if (cls == CLS_VILLAGE)
			return 2'b01;
		return 2'b00;
	endfunction

	// one stream word: update history and window, queue the pixel it completes
	task automatic dilate_word(input logic [1:0] cls_in);
		int unsigned       w;
		int unsigned       h;
		int unsigned       c;
		int unsigned       r;
		logic [1:0]        cls;
		logic [1:0]        seen;
		logic [1:0]        agg;
		logic [LINE_W-1:0] mask;
		logic [LINE_W-1:0] prior;
		pixel_word_t       word;

		w = width_reg;
		if (w < MIN_DIM)
			w = MIN_DIM;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		h = height_reg;
		if (h < MIN_DIM)
			h = MIN_DIM;
		c = col_pos;
		r = row_pos;

		// unused code, the two-pixel border and padding carry no centre
		cls = (cls_in == CLS_VILLAGE || cls_in == CLS_SHOP) ? cls_in : CLS_NONE;
		if (c < 2 || c + 2 >= w || r < 2 || r + 2 >= h)
			cls = CLS_NONE;

		// vertical summary over this row and the four above it
		seen = 2'b00;
		if (c < w) begin
			case (r)
				0:       mask = 8'h00;
				1:       mask = 8'h03;
				2:       mask = 8'h0F;
				3:       mask = 8'h3F;
				default: mask = 8'hFF;
			endcase
			prior = row_history[c] & mask;
			seen = summary_of(cls) | summary_of(prior[1:0]) | summary_of(prior[3:2]) |
				summary_of(prior[5:4]) | summary_of(prior[7:6]);
			row_history[c] = {prior[5:0], cls};
		end

		// horizontal window of five column summaries
		if (c == 0)
			summary_window = WIN_W'(seen);
		else
			summary_window = {summary_window[WIN_W-3:0], seen};

		if (c >= 2 && r >= 2 && c <= w + 1 && r <= h + 1) begin
			agg = summary_window[1:0] | summary_window[3:2] | summary_window[5:4] |
				summary_window[7:6] | summary_window[9:8];
			word.color = agg[1] ? COLOR_GREEN : (agg[0] ? COLOR_RED : COLOR_WHITE);
			word.last = (c == w + 1 && r == h + 1);
			expected_pixels.insert(expected_pixels.size(), word);
		end

		// raster position over the padded grid
		c++;
		if (c >= w + 2) begin
			c = 0;
			r++;
			if (r >= h + 2)
				r = 0;
		end
		col_pos = IW_W'(c);
		row_pos = ROW_W'(r);
	endtask

	// compare first, then predict: a word never leaves in the cycle it enters
	always @(posedge clk or negedge arst_n) begin
		pixel_word_t oldest;
		if (!arst_n) begin
			expected_pixels.delete();
			width_reg = IW_RESET;
			height_reg = IH_RESET;
			summary_window = '0;
			col_pos = '0;
			row_pos = '0;
			fail_count = 0;
		end else begin
			if (pix_valid && !pix_stall) begin
				if (expected_pixels.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: pixel word with none expected: color %0d last %0b",
							$realtime, pixel_color, frame_last);
				end else begin
					oldest = expected_pixels.pop_front();
					if (oldest.color !== pixel_color || oldest.last !== frame_last) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: pixel mismatch: color exp %0d got %0d, last exp %0b got %0b",
								$realtime, oldest.color, pixel_color, oldest.last, frame_last);
					end
				end
			end
			if (wr_en) begin
				if (wr_index == REG_IMAGE_WIDTH)
					width_reg = wr_data[IW_W-1:0];
				else
					height_reg = wr_data[IH_W-1:0];
			end
			if (src_valid && !src_stall)
				dilate_word(centre_class);
		end
		pending = expected_pixels.size();
		at_origin = (col_pos == '0 && row_pos == '0);
	end

endmodule

// ===== tb/sv/priority_square_dilation_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_square_dilation_tb
// Drives centre words into the square dilation block: part of a frame at the
// reset size, clamped sizes, mid-frame size changes, then small random frames
// with random gaps and stalls. A checker beside the block predicts every
// pixel word; this module gives the verdict.
// ----------------------------------------------------------------------------
module priority_square_dilation_tb;
	import psd_pkg::*;

	localparam int         MAX_WIDTH    = 1024;
	localparam int         MAX_GAP      = 13;
	localparam int         RANDOM_WORDS = 1200;
	localparam logic [1:0] CLS_UNUSED   = 2'd3;

	typedef enum int {FILL_RANDOM, FILL_SHOP, FILL_CYCLE} fill_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             wr_en        = 1'b0;
	logic             wr_index     = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0] wr_data      = '0;
	logic             src_valid    = 1'b0;
	logic             src_stall;
	logic [1:0]       centre_class = CLS_NONE;
	logic             pix_valid;
	logic             pix_stall    = 1'b0;
	logic [1:0]       pixel_color;
	logic             frame_last;

	int               fail_count;
	int               pending;
	logic             at_origin;

	// stimulus shape
	logic             idling      = 1'b1;
	fill_t            fill_mode   = FILL_RANDOM;
	int               busy_pct    = 10;
	logic [1:0]       cycle_class = CLS_NONE;
	int               words_sent  = 0;

	priority_square_dilation #(
		.MAX_WIDTH(MAX_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.centre_class(centre_class),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel_color(pixel_color),
		.frame_last(frame_last)
	);

	priority_square_dilation_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.centre_class(centre_class),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel_color(pixel_color),
		.frame_last(frame_last),
		.fail_count(fail_count),
		.pending(pending),
		.at_origin(at_origin)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int draw_gap();
		return idling ? $urandom_range(0, MAX_GAP) : 0;
	endfunction

	// mostly empty; busy sets the share of occupied positions
	function automatic logic [1:0] pick_class(input int busy);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll >= busy)
			return CLS_NONE;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return CLS_VILLAGE;
		if (roll < 9)
			return CLS_SHOP;
		return CLS_UNUSED;
	endfunction

	// pixel side: a fresh stall length for every word
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap != 0) begin
				pix_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			pix_stall <= 1'b0;
			@(posedge clk);
			while (!pix_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// one centre word, after a random gap; starts and ends at a falling edge
	task automatic send_centre();
		int         gap;
		logic [1:0] cls;
		gap = draw_gap();
		case (fill_mode)
			FILL_SHOP:  cls = CLS_SHOP;
			FILL_CYCLE: begin
				cls = cycle_class;
				cycle_class = cycle_class + 2'd1;
			end
			default:    cls = pick_class(busy_pct);
		endcase
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		centre_class <= cls;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	// drain every expected pixel, then cover words still in the pipeline
	task automatic settle();
		src_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		settle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	task automatic finish_frame();
		while (!at_origin)
			send_centre();
	endtask

	task automatic send_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input fill_t fill, input int busy);
		configure(w, h);
		fill_mode = fill;
		busy_pct = busy;
		cycle_class = CLS_NONE;
		send_centre();
		finish_frame();
	endtask

	initial begin
		int start;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// three rows and a bit at the reset size (66 words a row), full rate,
		// then shrink so the position lies beyond the new grid
		idling = 1'b0;
		fill_mode = FILL_RANDOM;
		busy_pct = 20;
		repeat (66 * 3 + 10) send_centre();
		configure(12'd6, 12'd6);
		finish_frame();
		idling = 1'b1;

		// smallest picture, one live centre; sizes below the minimum clamp
		send_frame(12'd5, 12'd5, FILL_SHOP, 0);
		send_frame(12'd4, 12'd3, FILL_CYCLE, 0);
		send_frame(12'd0, 12'd0, FILL_SHOP, 0);

		// shrink both sizes with the position beyond the new grid
		configure(12'd12, 12'd10);
		fill_mode = FILL_RANDOM;
		busy_pct = 40;
		repeat (14 * 8 + 9) send_centre();
		configure(12'd6, 12'd5);
		finish_frame();

		// grow the height partway down a frame
		configure(12'd6, 12'd6);
		repeat (8 * 3 + 4) send_centre();
		settle();
		write_reg(REG_IMAGE_HEIGHT, 12'd9);
		finish_frame();

		// small random frames, some below the minimum size
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			idling = ($urandom_range(0, 3) != 0);
			send_frame(CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) :
					$urandom_range(5, 20)),
				CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) :
					$urandom_range(5, 16)),
				FILL_RANDOM, int'($urandom_range(2, 60)));
		end

		src_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== priority_square_dilation.f =====
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_line_ram.sv
rtl/core/priority_square_dilation.sv
tb/sv/priority_square_dilation_checker.sv
tb/sv/priority_square_dilation_tb.sv
